>>> design/dsdu_pkg.sv
// Package for the descending sort unit with duplicate removal.
// Holds the store depth, the data width and the widths derived from the depth; no dependencies.
package dsdu_pkg;

	localparam int DEPTH = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

>>> design/dedupe_sort_descending_unit.sv
// Descending sort unit with duplicate removal: top level.
// Insert: an accepted word is compared with every stored value through the RAM read port,
// then decided in TAIL and written if it is unique and the store has room; one word at a time.
// A run emits n results, with one full RAM scan per result.
// Reset (arst_n, asynchronous, active low) empties the store and clears the flags.
// Depends on dsdu_pkg and dsdu_ram.
module dedupe_sort_descending_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  dsdu_pkg::data_t      value,
	input  logic                 end_of_set,
	output logic                 result_valid,
	input  logic                 result_ready,
	output dsdu_pkg::data_t      sorted_value,
	output logic                 run_last,
	output logic                 overflowed
);

	import dsdu_pkg::*;

	// IDLE waits for a word. SCAN reads every stored value to look for a duplicate,
	// TAIL checks the last read and writes the new value if it is unique and there is room.
	// PSCAN reads every stored value to find the largest one below the previous
	// result, PTAIL folds in the last read, POUT hands the result to the output
	// register as soon as it is free.
	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		TAIL,
		PSCAN,
		PTAIL,
		POUT
	} state_t;

	state_t state_q;
	data_t  val_q;
	logic   last_q;
	addr_t  addr_q;
	cnt_t   count_q;
	logic   dropped_q;
	logic   found_q;
	logic   pend_s1;
	addr_t  pass_q;
	data_t  best_q;
	logic   best_ok_q;
	data_t  thr_q;
	logic   thr_ok_q;
	logic   out_valid_q;
	data_t  out_value_q;
	logic   out_last_q;
	logic   out_ovf_q;

	data_t  rdata;
	logic   hit;
	logic   found;
	logic   room;
	logic   ram_we;
	logic   addr_end;
	logic   elig;
	logic   take;
	data_t  best_nx;
	logic   slot_free;

	// The store. Only the first count_q entries are ever read.
	dsdu_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(val_q),
		.raddr(addr_q),
		.rdata(rdata)
	);

	assign item_ready   = (state_q == IDLE);
	assign result_valid = out_valid_q;
	assign sorted_value = out_value_q;
	assign run_last     = out_last_q;
	assign overflowed   = out_ovf_q;

	// Data from the RAM is valid in the cycle after a read was issued.
	assign hit   = pend_s1 && (rdata == val_q);
	assign found = found_q || hit;
	assign room  = (count_q < cnt_t'(DEPTH));
	assign ram_we = (state_q == TAIL) && !found && room;

	// The last stored value has been addressed.
	assign addr_end = ({1'b0, addr_q} == cnt_t'(count_q - cnt_t'(1)));

	// A stored value takes part in this pass only if it lies below the previous
	// result; the first pass of a run takes every value.
	assign elig    = pend_s1 && (!thr_ok_q || (rdata < thr_q));
	assign take    = elig && (!best_ok_q || (rdata > best_q));
	assign best_nx = take ? rdata : best_q;

	// The output register can take a new word when empty or being emptied.
	assign slot_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			val_q       <= '0;
			last_q      <= 1'b0;
			addr_q      <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			found_q     <= 1'b0;
			pend_s1     <= 1'b0;
			pass_q      <= '0;
			best_q      <= '0;
			best_ok_q   <= 1'b0;
			thr_q       <= '0;
			thr_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			pend_s1 <= (state_q == SCAN) || (state_q == PSCAN);

			// In POUT the output register is loaded below whenever it is being emptied.
			if (out_valid_q && result_ready && (state_q != POUT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				IDLE: begin
					if (item_valid) begin
						val_q   <= value;
						last_q  <= end_of_set;
						addr_q  <= '0;
						found_q <= 1'b0;
						// With an empty store there is nothing to compare against.
						state_q <= (count_q == '0) ? TAIL : SCAN;
					end
				end
				SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (addr_end) begin
						state_q <= TAIL;
					end else begin
						addr_q <= addr_q + addr_t'(1);
					end
				end
				TAIL: begin
					cnt_t n_cnt;
					n_cnt = count_q;
					if (!found) begin
						if (room) begin
							n_cnt = count_q + cnt_t'(1);
						end else begin
							dropped_q <= 1'b1;
						end
					end
					count_q <= n_cnt;
					if (last_q) begin
						// The final word of a set always leaves the store non-empty.
						addr_q    <= '0;
						pass_q    <= '0;
						best_ok_q <= 1'b0;
						thr_ok_q  <= 1'b0;
						state_q   <= PSCAN;
					end else begin
						state_q <= IDLE;
					end
				end
				PSCAN: begin
					best_q    <= best_nx;
					best_ok_q <= best_ok_q || take;
					if (addr_end) begin
						state_q <= PTAIL;
					end else begin
						addr_q <= addr_q + addr_t'(1);
					end
				end
				PTAIL: begin
					best_q    <= best_nx;
					best_ok_q <= best_ok_q || take;
					state_q   <= POUT;
				end
				POUT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= best_q;
						out_ovf_q   <= dropped_q;
						out_last_q  <= ({1'b0, pass_q} == cnt_t'(count_q - cnt_t'(1)));
						thr_q       <= best_q;
						thr_ok_q    <= 1'b1;
						if ({1'b0, pass_q} == cnt_t'(count_q - cnt_t'(1))) begin
							// Run complete: the store is empty again.
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= IDLE;
						end else begin
							pass_q    <= pass_q + addr_t'(1);
							addr_q    <= '0;
							best_ok_q <= 1'b0;
							state_q   <= PSCAN;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/dsdu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used by the top level of the descending sort unit.
module dsdu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
